FILE: rtl/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FRJS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define FRJS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/frjs_pkg.sv
`default_nettype none

package frjs_pkg;

	localparam int unsigned MAX_RECORDS = 4096;
	localparam int unsigned SLOT_W = $clog2(MAX_RECORDS + 1);
	localparam int unsigned FREE_W = 12;
	localparam int unsigned LEN_W = 5;

	localparam logic [31:0] REC_MAGIC = 32'h4F46_4343;
	localparam logic [31:0] REC_VERSION = 32'h0000_0001;
	localparam logic [31:0] REC_COMMIT = 32'h434F_4D54;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;
	localparam logic [LEN_W-1:0] PAYLOAD_BYTES = 5'd16;
	localparam logic [LEN_W-1:0] EXP_LEN_RESET = 5'd16;

	// word positions inside a record
	localparam logic [3:0] POS_MAGIC = 4'd0;
	localparam logic [3:0] POS_VERSION = 4'd1;
	localparam logic [3:0] POS_SEQ = 4'd2;
	localparam logic [3:0] POS_LEN = 4'd3;
	localparam logic [3:0] POS_PAY0 = 4'd4;
	localparam logic [3:0] POS_PAY1 = 4'd5;
	localparam logic [3:0] POS_PAY2 = 4'd6;
	localparam logic [3:0] POS_PAY3 = 4'd7;
	localparam logic [3:0] POS_CRC = 4'd8;
	localparam logic [3:0] POS_COMMIT = 4'd9;

	localparam logic [1:0] RS_OK = 2'd0;
	localparam logic [1:0] RS_EMPTY = 2'd1;
	localparam logic [1:0] RS_ERROR = 2'd2;

	localparam logic ADDR_EXP_LEN = 1'b0;

	typedef logic [3:0][31:0] payload_t;

	typedef struct packed {
		logic valid;
		logic [31:0] word;
		logic last;
	} frjs_step_t;

	typedef struct packed {
		logic [1:0] read_status;
		payload_t payload;
		logic [31:0] newest_sequence;
		logic write_status;
		logic [31:0] next_sequence;
		logic [FREE_W-1:0] free_slot;
	} frjs_result_t;

	// CRC of a single set input bit after 32 shift steps (constant per bit)
	function automatic logic [31:0] crc_col(input int unsigned bitpos);
		logic [31:0] c;
		c = 32'd1 << bitpos;
		for (int k = 0; k < 32; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// one word of reflected CRC-32; linear in x = crc ^ word
	function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
		logic [31:0] x;
		logic [31:0] r;
		x = crc ^ w;
		r = '0;
		for (int unsigned i = 0; i < 32; i++) begin
			r = r ^ (x[i] ? crc_col(i) : 32'd0);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/flash_record_journal_scanner.sv
// A word is registered at the input, then scanned; the result is registered
// in result_q, and out_valid rises once the final word of a region has been scanned.
// One flash word per cycle while the input is not stalled, set by the combinational CRC/check stage.
// The input stalls only while a finished result waits behind a stalled output.
// Reset (arst_n low, asynchronous) clears scan state and sets expected_length to 16.
`default_nettype none

module flash_record_journal_scanner (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [31:0] flash_word,
	input wire logic end_of_region,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] read_status,
	output logic [31:0] payload_word_0,
	output logic [31:0] payload_word_1,
	output logic [31:0] payload_word_2,
	output logic [31:0] payload_word_3,
	output logic [31:0] newest_sequence,
	output logic write_status,
	output logic [31:0] next_sequence,
	output logic [11:0] free_slot
);

	logic [frjs_pkg::LEN_W-1:0] exp_len_q;
	logic valid_s1;
	logic [31:0] word_s1;
	logic last_s1;
	logic out_valid_q;
	logic s1_go;
	logic in_take;
	frjs_pkg::frjs_step_t step;
	frjs_pkg::frjs_result_t result;
	frjs_pkg::frjs_result_t result_q;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == frjs_pkg::ADDR_EXP_LEN) ?
		{{(32 - frjs_pkg::LEN_W){1'b0}}, exp_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= frjs_pkg::EXP_LEN_RESET;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == frjs_pkg::ADDR_EXP_LEN)) begin
			exp_len_q <= pwdata[frjs_pkg::LEN_W-1:0];
		end
	end

	// input stage
	assign s1_go = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !s1_go;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= flash_word;
			last_s1 <= end_of_region;
		end
	end

	assign step.valid = s1_go;
	assign step.word = word_s1;
	assign step.last = last_s1;

	frjs_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.exp_len(exp_len_q),
		.result(result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign read_status = result_q.read_status;
	assign payload_word_0 = result_q.payload[0];
	assign payload_word_1 = result_q.payload[1];
	assign payload_word_2 = result_q.payload[2];
	assign payload_word_3 = result_q.payload[3];
	assign newest_sequence = result_q.newest_sequence;
	assign write_status = result_q.write_status;
	assign next_sequence = result_q.next_sequence;
	assign free_slot = result_q.free_slot;

endmodule

`default_nettype wire

FILE: rtl/frjs_scan.sv
`default_nettype none

module frjs_scan (
	input wire logic clk,
	input wire logic arst_n,
	input wire frjs_pkg::frjs_step_t step,
	input wire logic [frjs_pkg::LEN_W-1:0] exp_len,
	output frjs_pkg::frjs_result_t result
);

	logic [3:0] pos_q;
	logic [frjs_pkg::SLOT_W-1:0] slot_q;
	logic [31:0] crc_q;
	logic all_erased_q;
	logic fields_ok_q;
	logic [31:0] cur_seq_q;
	frjs_pkg::payload_t cur_pay_q;
	logic best_found_q;
	logic [31:0] best_seq_q;
	frjs_pkg::payload_t best_pay_q;
	logic nonempty_q;
	logic [31:0] wmax_q;
	logic free_found_q;
	logic [frjs_pkg::FREE_W-1:0] free_idx_q;

	logic [3:0] pos_n;
	logic [frjs_pkg::SLOT_W-1:0] slot_n;
	logic [31:0] crc_n;
	logic all_erased_n;
	logic fields_ok_n;
	logic [31:0] cur_seq_n;
	frjs_pkg::payload_t cur_pay_n;
	logic best_found_n;
	logic [31:0] best_seq_n;
	frjs_pkg::payload_t best_pay_n;
	logic nonempty_n;
	logic [31:0] wmax_n;
	logic free_found_n;
	logic [frjs_pkg::FREE_W-1:0] free_idx_n;
	logic len_ok;
	logic field_ok;
	logic werr;
	logic [31:0] w;

	assign w = step.word;
	assign len_ok = (exp_len != '0) && (exp_len <= frjs_pkg::PAYLOAD_BYTES);

	always_comb begin
		pos_n = pos_q;
		slot_n = slot_q;
		crc_n = crc_q;
		all_erased_n = all_erased_q && (w == frjs_pkg::ERASED_WORD);
		cur_seq_n = cur_seq_q;
		cur_pay_n = cur_pay_q;
		best_found_n = best_found_q;
		best_seq_n = best_seq_q;
		best_pay_n = best_pay_q;
		nonempty_n = nonempty_q;
		wmax_n = wmax_q;
		free_found_n = free_found_q;
		free_idx_n = free_idx_q;
		field_ok = 1'b1;

		if (pos_q < frjs_pkg::POS_CRC) begin
			crc_n = frjs_pkg::crc_word(crc_q, w);
		end

		case (pos_q)
			frjs_pkg::POS_MAGIC: begin
				field_ok = (w == frjs_pkg::REC_MAGIC);
			end
			frjs_pkg::POS_VERSION: begin
				field_ok = (w == frjs_pkg::REC_VERSION);
			end
			frjs_pkg::POS_SEQ: begin
				cur_seq_n = w;
			end
			frjs_pkg::POS_LEN: begin
				field_ok = (w == {{(32 - frjs_pkg::LEN_W){1'b0}}, exp_len});
			end
			frjs_pkg::POS_PAY0, frjs_pkg::POS_PAY1,
			frjs_pkg::POS_PAY2, frjs_pkg::POS_PAY3: begin
				cur_pay_n[pos_q[1:0]] = w;
			end
			frjs_pkg::POS_CRC: begin
				field_ok = (w == ~crc_q);
			end
			default: begin
				field_ok = (w == frjs_pkg::REC_COMMIT);
			end
		endcase
		fields_ok_n = fields_ok_q && field_ok;

		if (pos_q >= frjs_pkg::POS_COMMIT) begin
			if (slot_q < frjs_pkg::SLOT_W'(frjs_pkg::MAX_RECORDS)) begin
				if (all_erased_n) begin
					if (!free_found_q) begin
						free_found_n = 1'b1;
						free_idx_n = frjs_pkg::FREE_W'(slot_q);
					end
				end else begin
					nonempty_n = 1'b1;
					if (fields_ok_n && len_ok) begin
						if (!best_found_q || (cur_seq_q > best_seq_q)) begin
							best_found_n = 1'b1;
							best_seq_n = cur_seq_q;
							best_pay_n = cur_pay_q;
						end
						if (cur_seq_q > wmax_q) begin
							wmax_n = cur_seq_q;
						end
					end
				end
				slot_n = slot_q + frjs_pkg::SLOT_W'(1);
			end
			pos_n = '0;
			crc_n = '1;
			all_erased_n = 1'b1;
			fields_ok_n = 1'b1;
		end else begin
			pos_n = pos_q + 4'd1;
		end
	end

	// report from the state after this word
	always_comb begin
		if (!len_ok) begin
			result.read_status = frjs_pkg::RS_ERROR;
		end else if (best_found_n) begin
			result.read_status = frjs_pkg::RS_OK;
		end else if (nonempty_n) begin
			result.read_status = frjs_pkg::RS_ERROR;
		end else begin
			result.read_status = frjs_pkg::RS_EMPTY;
		end

		result.payload = '0;
		if (result.read_status == frjs_pkg::RS_OK) begin
			for (int b = 0; b < 16; b++) begin
				if (frjs_pkg::LEN_W'(b) < exp_len) begin
					result.payload[b / 4][8 * (b % 4) +: 8] = best_pay_n[b / 4][8 * (b % 4) +: 8];
				end
			end
		end
		result.newest_sequence = (result.read_status == frjs_pkg::RS_OK) ? best_seq_n : '0;

		werr = !len_ok || !free_found_n || (wmax_n == '1);
		result.write_status = werr;
		result.next_sequence = werr ? '0 : (wmax_n + 32'd1);
		result.free_slot = free_found_n ? free_idx_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			slot_q <= '0;
			crc_q <= '1;
			all_erased_q <= 1'b1;
			fields_ok_q <= 1'b1;
			cur_seq_q <= '0;
			best_found_q <= 1'b0;
			best_seq_q <= '0;
			nonempty_q <= 1'b0;
			wmax_q <= '0;
			free_found_q <= 1'b0;
			free_idx_q <= '0;
		end else if (step.valid) begin
			if (step.last) begin
				pos_q <= '0;
				slot_q <= '0;
				crc_q <= '1;
				all_erased_q <= 1'b1;
				fields_ok_q <= 1'b1;
				cur_seq_q <= '0;
				best_found_q <= 1'b0;
				best_seq_q <= '0;
				nonempty_q <= 1'b0;
				wmax_q <= '0;
				free_found_q <= 1'b0;
				free_idx_q <= '0;
			end else begin
				pos_q <= pos_n;
				slot_q <= slot_n;
				crc_q <= crc_n;
				all_erased_q <= all_erased_n;
				fields_ok_q <= fields_ok_n;
				cur_seq_q <= cur_seq_n;
				best_found_q <= best_found_n;
				best_seq_q <= best_seq_n;
				nonempty_q <= nonempty_n;
				wmax_q <= wmax_n;
				free_found_q <= free_found_n;
				free_idx_q <= free_idx_n;
			end
		end
	end

	// payload stores: read only after being written
	always_ff @(posedge clk) begin
		if (step.valid) begin
			cur_pay_q <= cur_pay_n;
			best_pay_q <= best_pay_n;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/frjs_port_chk.sv
`default_nettype none
`include "assert_macros.svh"

module frjs_port_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [1:0] read_status,
	input wire logic [31:0] payload_word_0,
	input wire logic [31:0] newest_sequence,
	input wire logic write_status,
	input wire logic [31:0] next_sequence
);

	`FRJS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`FRJS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(next_sequence))
	`FRJS_ASSERT_IMPL(a_rd_err_zero, clk, arst_n, out_valid && (read_status != frjs_pkg::RS_OK), (payload_word_0 == 32'd0) && (newest_sequence == 32'd0))
	`FRJS_ASSERT_IMPL(a_wr_seq, clk, arst_n, out_valid, write_status ? (next_sequence == 32'd0) : (next_sequence != 32'd0))

endmodule

bind flash_record_journal_scanner frjs_port_chk u_port_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.read_status(read_status),
	.payload_word_0(payload_word_0),
	.newest_sequence(newest_sequence),
	.write_status(write_status),
	.next_sequence(next_sequence)
);

`default_nettype wire
